/* rtl/moving_average_crossover_macros.svh */
// ----------------------------------------------------------------------------
// moving average crossover assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_CROSSOVER_MACROS_SVH
`define MOVING_AVERAGE_CROSSOVER_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define MAC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define MAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MAC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)

`define MAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

/* rtl/mac_pkg.sv */
// ----------------------------------------------------------------------------
// mac_pkg
// shared widths, register indexes, reset values, side codes, output queue sizes and the result item type
// ----------------------------------------------------------------------------
`default_nettype none

package mac_pkg;

    // field widths
    localparam int SYM_W      = 6;
    localparam int PRICE_W    = 32;
    localparam int PERIOD_W   = 9;
    localparam int QTY_W      = 16;

    // stream widths, tdata padded to whole bytes
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 1;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_PERIOD   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PERIOD    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRADE_QUANTITY = 2'd2;

    localparam logic [PERIOD_W-1:0] RST_SHORT_PERIOD   = 9'd5;
    localparam logic [PERIOD_W-1:0] RST_LONG_PERIOD    = 9'd20;
    localparam logic [QTY_W-1:0]    RST_TRADE_QUANTITY = 16'd100;

    // side codes
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // output queue
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = 3;
    localparam int OUTQ_CNT_W = 4;

    typedef struct packed {
        logic [QTY_W-1:0] quantity;
        logic             side;
        logic [SYM_W-1:0] symbol;
    } t_signal;

endpackage

`default_nettype wire

/* rtl/mac_outq.sv */
// ----------------------------------------------------------------------------
// mac_outq
// small result queue between the compare stage and the master stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_crossover_macros.svh"

module mac_outq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire mac_pkg::t_signal                  i_push_data,
    output logic [mac_pkg::OUTQ_CNT_W-1:0]         o_count,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output mac_pkg::t_signal                       o_data
);
    import mac_pkg::*;

    t_signal                 r_store [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_wr_ptr;
    logic [OUTQ_PTR_W-1:0]   r_rd_ptr;
    logic [OUTQ_CNT_W-1:0]   r_count;
    logic                    pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_store[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // the upstream credit check must never overfill the queue
    `MAC_ASSERT_NOW(a_outq_no_overflow, i_clk, i_rst_n, i_push, r_count < OUTQ_CNT_W'(OUTQ_DEPTH), "result queue pushed while full")

endmodule

`default_nettype wire

/* rtl/moving_average_crossover.sv */
// ----------------------------------------------------------------------------
// moving_average_crossover
// per-symbol simple moving average crossover detector
// result path: a price item moves through the stage registers, then the result queue
// throughput: one price item per cycle while the queue credit allows, set by the
//   single write port of the per-symbol state memory and the two read ports of the prefix memory
// reset: synchronous, active low; registers return to 5/20/100, per-symbol
//   state is cleared through valid bits at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

`include "moving_average_crossover_macros.svh"

module moving_average_crossover #(
    parameter int SYMBOLS    = 64,
    parameter int MAX_PERIOD = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [mac_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire logic [mac_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // price items
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [mac_pkg::S_TDATA_W-1:0]     i_s_tdata,   // symbol_index, price
    // signal items
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [mac_pkg::M_TDATA_W-1:0]          o_m_tdata,   // signal_symbol, quantity
    output logic [mac_pkg::M_TUSER_W-1:0]          o_m_tuser    // side
);
    import mac_pkg::*;

    // index widths
    localparam int SA     = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;   // symbol address
    localparam int RA     = $clog2(MAX_PERIOD);                    // ring slot
    localparam int PW     = $clog2(MAX_PERIOD + 1);                // effective period
    localparam int CW     = (PW > PERIOD_W) ? PW : PERIOD_W;       // period clamp math
    localparam int EXT_W  = SA + SYM_W;                            // symbol range check
    localparam int AA     = $clog2(SYMBOLS * MAX_PERIOD);          // prefix memory address
    // a window sum of up to MAX_PERIOD prices fits, so sums wrap safely mod 2^SUM_W
    localparam int SUM_W  = PRICE_W + RA;
    localparam int PROD_W = SUM_W + PW;
    localparam int OCC_W  = OUTQ_CNT_W + 1;

    // per-symbol state word: next ring slot, fill count, running price total
    typedef struct packed {
        logic [RA-1:0]    wp;
        logic [PW-1:0]    fill;
        logic [SUM_W-1:0] cum;
    } t_meta;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0] r_cfg_short;
    logic [PERIOD_W-1:0] r_cfg_long;
    logic [QTY_W-1:0]    r_cfg_qty;
    logic [PW-1:0]       r_lp;      // effective long period
    logic [PW-1:0]       r_sp;      // effective short period
    logic [CW-1:0]       lp_x;
    logic [CW-1:0]       sp_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_short <= RST_SHORT_PERIOD;
            r_cfg_long  <= RST_LONG_PERIOD;
            r_cfg_qty   <= RST_TRADE_QUANTITY;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SHORT_PERIOD:   r_cfg_short <= i_cfg_wdata[PERIOD_W-1:0];
                REG_LONG_PERIOD:    r_cfg_long  <= i_cfg_wdata[PERIOD_W-1:0];
                REG_TRADE_QUANTITY: r_cfg_qty   <= i_cfg_wdata[QTY_W-1:0];
                default:            r_cfg_short <= r_cfg_short;
            endcase
        end
    end

    // clamp long to 1..MAX_PERIOD, short to 1..long
    always_comb begin
        lp_x = CW'(r_cfg_long);
        if (lp_x == '0) begin
            lp_x = CW'(1);
        end else if (lp_x > CW'(MAX_PERIOD)) begin
            lp_x = CW'(MAX_PERIOD);
        end
        sp_x = CW'(r_cfg_short);
        if (sp_x == '0) begin
            sp_x = CW'(1);
        end
        if (sp_x > lp_x) begin
            sp_x = lp_x;
        end
    end

    // registered copy; config is to be changed by the user only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        r_lp <= PW'(lp_x);
        r_sp <= PW'(sp_x);
    end

    // ------------------------------------------------------------------
    // input accept, per-symbol state read
    // ------------------------------------------------------------------
    logic [SYM_W-1:0]    in_sym;
    logic [PRICE_W-1:0]  in_price;
    logic [EXT_W-1:0]    in_ext;
    logic [SA-1:0]       in_idx;
    logic                in_range;
    logic                accept;

    logic [OCC_W-1:0]    occ;
    logic [OUTQ_CNT_W-1:0] q_count;

    assign in_sym   = i_s_tdata[SYM_W-1:0];
    assign in_price = i_s_tdata[SYM_W +: PRICE_W];
    assign in_ext   = EXT_W'(in_sym);
    assign in_idx   = in_ext[SA-1:0];
    assign in_range = (in_ext < EXT_W'(SYMBOLS));
    assign accept   = i_s_tvalid && o_s_tready;

    // stage registers
    logic                r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    logic [SYM_W-1:0]    r_s1_sym, r_s2_sym, r_s3_sym, r_s4_sym;
    logic [SA-1:0]       r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic [PRICE_W-1:0]  r_s1_price;
    logic                r_s1_mvld;
    t_meta               r_meta_rd;

    // credit check: queued results plus items still in the pipe never exceed the queue
    assign occ = OCC_W'(q_count) + OCC_W'(r_s1_vld) + OCC_W'(r_s2_vld)
               + OCC_W'(r_s3_vld) + OCC_W'(r_s4_vld);
    assign o_s_tready = (occ < OCC_W'(OUTQ_DEPTH));

    // per-symbol state memory, one write and one read per cycle
    t_meta               r_meta_mem [SYMBOLS];
    logic [SYMBOLS-1:0]  r_meta_vld;
    t_meta               n_meta;

    // last write-back, forwarded to a same-symbol item right behind it
    logic                r_wb_vld;
    logic [SA-1:0]       r_wb_idx;
    t_meta               r_wb_data;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_meta_mem[r_s1_idx] <= n_meta;
        end
        r_meta_rd <= r_meta_mem[in_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_vld <= '0;
            r_s1_mvld  <= 1'b0;
            r_s1_vld   <= 1'b0;
            r_wb_vld   <= 1'b0;
        end else begin
            if (r_s1_vld) begin
                r_meta_vld[r_s1_idx] <= 1'b1;
            end
            r_s1_mvld <= r_meta_vld[in_idx];
            // out-of-range symbols are taken and dropped here
            r_s1_vld  <= accept && in_range;
            r_wb_vld  <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sym   <= in_sym;
        r_s1_idx   <= in_idx;
        r_s1_price <= in_price;
        r_wb_idx   <= r_s1_idx;
        r_wb_data  <= n_meta;
    end

    // ------------------------------------------------------------------
    // stage 1: update ring position, fill count, prefix slot addresses and running total
    // ------------------------------------------------------------------
    t_meta               meta;
    logic [PW-1:0]       fill;
    logic                eval;
    logic [RA-1:0]       off_s, off_l;
    logic [RA:0]         d_s, d_l;
    logic [RA-1:0]       slot_s, slot_l;
    logic [AA-1:0]       base;
    logic [AA-1:0]       addr_w, addr_s, addr_l;

    always_comb begin
        // never-touched symbols read as zero state
        meta = r_s1_mvld ? r_meta_rd : '0;
        if (r_wb_vld && (r_wb_idx == r_s1_idx)) begin
            meta = r_wb_data;
        end

        // fill count follows the current long period, clamps when it shrinks
        fill = meta.fill;
        if (fill > r_lp) begin
            fill = r_lp;
        end
        if (fill < r_lp) begin
            fill = fill + 1'b1;
        end
        eval = (fill == r_lp);

        n_meta.wp   = (meta.wp == RA'(MAX_PERIOD - 1)) ? '0 : meta.wp + 1'b1;
        n_meta.fill = fill;
        n_meta.cum  = meta.cum + SUM_W'(r_s1_price);

        // the oldest entry of an n-wide window sits n-1 slots behind this one
        off_s  = RA'(r_sp - 1'b1);
        off_l  = RA'(r_lp - 1'b1);
        d_s    = {1'b0, meta.wp} - {1'b0, off_s};
        d_l    = {1'b0, meta.wp} - {1'b0, off_l};
        slot_s = d_s[RA] ? RA'(d_s + (RA+1)'(MAX_PERIOD)) : d_s[RA-1:0];
        slot_l = d_l[RA] ? RA'(d_l + (RA+1)'(MAX_PERIOD)) : d_l[RA-1:0];

        base   = AA'(r_s1_idx) * AA'(MAX_PERIOD);
        addr_w = base + AA'(meta.wp);
        addr_s = base + AA'(slot_s);
        addr_l = base + AA'(slot_l);
    end

    // prefix memory: each ring slot holds the running total before its price,
    // so a window sum is the total now minus the entry at the window's oldest slot
    logic [SUM_W-1:0]    r_pfx_mem [SYMBOLS * MAX_PERIOD];
    logic [SUM_W-1:0]    r_cs, r_cl;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_pfx_mem[addr_w] <= meta.cum;
        end
        r_cs <= r_pfx_mem[addr_s];
        r_cl <= r_pfx_mem[addr_l];
    end

    logic [SUM_W-1:0]    r_s2_cum, r_s2_cb;
    logic                r_s2_fws, r_s2_fwl;

    always_ff @(posedge i_clk) begin
        r_s2_sym <= r_s1_sym;
        r_s2_idx <= r_s1_idx;
        r_s2_cum <= n_meta.cum;
        r_s2_cb  <= meta.cum;
        // a one-wide window starts at the slot written this cycle
        r_s2_fws <= (r_sp == PW'(1));
        r_s2_fwl <= (r_lp == PW'(1));
    end

    // ------------------------------------------------------------------
    // stage 2: window sums
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]    cs, cl;
    logic [SUM_W-1:0]    r_s3_ss, r_s3_ls;

    assign cs = r_s2_fws ? r_s2_cb : r_cs;
    assign cl = r_s2_fwl ? r_s2_cb : r_cl;

    always_ff @(posedge i_clk) begin
        r_s3_sym <= r_s2_sym;
        r_s3_idx <= r_s2_idx;
        r_s3_ss  <= r_s2_cum - cs;
        r_s3_ls  <= r_s2_cum - cl;
    end

    // ------------------------------------------------------------------
    // stage 3: cross-multiply so the averages compare without division
    // ------------------------------------------------------------------
    logic [PROD_W-1:0]   r_s4_ps, r_s4_pl;

    always_ff @(posedge i_clk) begin
        r_s4_sym <= r_s3_sym;
        r_s4_idx <= r_s3_idx;
        r_s4_ps  <= PROD_W'(r_s3_ss) * PROD_W'(r_lp);
        r_s4_pl  <= PROD_W'(r_s3_ls) * PROD_W'(r_sp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            // items still warming up stop after stage 1
            r_s2_vld <= r_s1_vld && eval;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: compare, crossover flags, result
    // ------------------------------------------------------------------
    logic [SYMBOLS-1:0]  r_known;   // first full window recorded
    logic [SYMBOLS-1:0]  r_above;   // last short-above-long result
    logic                above;
    logic                push;
    t_signal             push_data;
    t_signal             q_data;

    // equal averages count as not above
    assign above = (r_s4_ps > r_s4_pl);
    assign push  = r_s4_vld && r_known[r_s4_idx] && (above != r_above[r_s4_idx]);

    always_comb begin
        push_data.symbol   = r_s4_sym;
        push_data.side     = above ? SIDE_BUY : SIDE_SELL;
        push_data.quantity = r_cfg_qty;
    end

    // read and written in the same stage, so no hazard between items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
            r_above <= '0;
        end else if (r_s4_vld) begin
            r_known[r_s4_idx] <= 1'b1;
            r_above[r_s4_idx] <= above;
        end
    end

    mac_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_count     (q_count),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (q_data)
    );

    assign o_m_tdata = {{(M_TDATA_W - SYM_W - QTY_W){1'b0}}, q_data.quantity, q_data.symbol};
    assign o_m_tuser = M_TUSER_W'(q_data.side);

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MAC_ASSERT_NOW(a_credit_bound, i_clk, i_rst_n, 1'b1, occ <= OCC_W'(OUTQ_DEPTH), "queue credit exceeded")
    `MAC_ASSERT_NEXT(a_known_set, i_clk, i_rst_n, r_s4_vld, r_known[$past(r_s4_idx)], "crossover flag not recorded")
    `MAC_ASSERT_NEXT(a_wp_wrap, i_clk, i_rst_n, r_s1_vld, r_wb_vld && (r_wb_data.wp < RA'(MAX_PERIOD - 1) || r_wb_data.wp == RA'(MAX_PERIOD - 1)), "ring position out of range")

endmodule

`default_nettype wire
